@@ design/skrt_pkg.sv @@
// shared types and constants for the sorted keyed record table
// no dependencies; imported by skrt_mem and sorted_keyed_record_table_top
`default_nettype none

package skrt_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned NAME_BYTES_DEF = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] hash;
    logic [63:0] name;
    logic [31:0] value;
  } rec_t;

endpackage

`default_nettype wire

@@ design/skrt_mem.sv @@
// record store: one write port, one read port with registered read data
// depends on skrt_pkg for the record type
`default_nettype none

module skrt_mem #(
  parameter int unsigned DEPTH = skrt_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic           clk_i,
  input  wire logic           wr_en_i,
  input  wire logic [AW-1:0]  wr_addr_i,
  input  wire skrt_pkg::rec_t wr_data_i,
  input  wire logic [AW-1:0]  rd_addr_i,
  output skrt_pkg::rec_t      rd_data_o
);
  import skrt_pkg::*;

  rec_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

@@ design/sorted_keyed_record_table_top.sv @@
// sorted keyed record table: sequencer, compare unit and output register
// depends on skrt_pkg and skrt_mem
`default_nettype none

// Table of up to CAPACITY records (hash, name, value) held in ascending hash
// order in a record memory with one write port and one registered read port.
// One request is taken at a time; in_stall_o stays high until its word is in
// the output register. A request scans the records from slot 0 with one shared
// compare unit, each slot read and then compared, stopping at a match, at a
// larger hash or at the last record. An insert then moves each later record up
// one slot and a delete moves each later record down, each moved record read
// and then written back. The record count is a register, so the table is empty
// straight after reset with no clearing pass. Names are cut at their first zero
// byte and at NAME_BYTES.
module sorted_keyed_record_table_top #(
  parameter int unsigned CAPACITY   = skrt_pkg::CAPACITY_DEF,
  parameter int unsigned NAME_BYTES = skrt_pkg::NAME_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] key_hash_i,
  input  wire logic [63:0] key_name_i,
  input  wire logic [31:0] value_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             found_o,
  output logic [31:0]      value_out_o
);
  import skrt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_N = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE   = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_DECIDE,
    S_SH_CHK,
    S_SH_RD,
    S_SH_WR,
    S_WR,
    S_FIN
  } state_e;

  state_e         state_q, state_d;
  req_e           req_q, req_d;
  logic [31:0]    hash_q, hash_d;
  logic [63:0]    name_q, name_d;
  logic [31:0]    val_in_q, val_in_d;
  logic [CW-1:0]  n_q, n_d;
  logic [CW-1:0]  i_q, i_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic           pos_set_q, pos_set_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           match_q, match_d;
  logic [31:0]    match_val_q, match_val_d;
  logic [AW-1:0]  wr_addr_q, wr_addr_d;
  rec_t           wr_rec_q, wr_rec_d;
  status_e        res_status_q, res_status_d;
  logic [31:0]    res_val_q, res_val_d;
  logic           out_valid_q, out_valid_d;
  status_e        out_status_q, out_status_d;
  logic           out_found_q, out_found_d;
  logic [31:0]    out_val_q, out_val_d;

  logic [63:0]    name_norm;
  logic           name_alive;
  logic [CW-1:0]  rd_src;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  rec_t           mem_wdata;
  rec_t           mem_rdata;
  logic           hit;
  logic           load_out;

  // name ends at its first zero byte and at NAME_BYTES
  always_comb begin
    name_norm  = '0;
    name_alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (name_alive && (b < NAME_BYTES) && (key_name_i[8*b +: 8] != 8'd0)) begin
        name_norm[8*b +: 8] = key_name_i[8*b +: 8];
      end else begin
        name_alive = 1'b0;
      end
    end
  end

  // shared compare unit on the record just read
  assign hit = (mem_rdata.hash == hash_q) && (mem_rdata.name == name_q);

  always_comb begin
    if (state_q == S_SH_RD) begin
      rd_src = (req_q == REQ_INSERT) ? (i_q - ONE) : (i_q + ONE);
    end else begin
      rd_src = i_q;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i_q[AW-1:0];
    mem_wdata = mem_rdata;
    if (state_q == S_SH_WR) begin
      mem_we = 1'b1;
    end else if (state_q == S_WR) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = wr_rec_q;
    end
  end

  skrt_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (rd_src[AW-1:0]),
    .rd_data_o (mem_rdata)
  );

  assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    hash_d       = hash_q;
    name_d       = name_q;
    val_in_d     = val_in_q;
    n_d          = n_q;
    i_d          = i_q;
    pos_d        = pos_q;
    pos_set_d    = pos_set_q;
    idx_d        = idx_q;
    match_d      = match_q;
    match_val_d  = match_val_q;
    wr_addr_d    = wr_addr_q;
    wr_rec_d     = wr_rec_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_val_d    = out_val_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d     = req_e'(req_type_i);
          hash_d    = key_hash_i;
          name_d    = name_norm;
          val_in_d  = value_in_i;
          i_d       = '0;
          pos_d     = n_q;
          pos_set_d = 1'b0;
          match_d   = 1'b0;
          state_d   = (n_q == '0) ? S_DECIDE : S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!pos_set_q && (mem_rdata.hash >= hash_q)) begin
          pos_d     = i_q;
          pos_set_d = 1'b1;
        end
        if (hit) begin
          match_d     = 1'b1;
          idx_d       = i_q;
          match_val_d = mem_rdata.value;
          state_d     = S_DECIDE;
        end else if ((mem_rdata.hash > hash_q) || ((i_q + ONE) == n_q)) begin
          state_d = S_DECIDE;
        end else begin
          i_d     = i_q + ONE;
          state_d = S_RD;
        end
      end
      S_DECIDE: begin
        res_status_d = ST_DONE;
        res_val_d    = '0;
        state_d      = S_FIN;
        case (req_q)
          REQ_INSERT: begin
            if (match_q) begin
              res_status_d = ST_MISS;
            end else if (n_q == CAP_N) begin
              res_status_d = ST_FULL;
            end else begin
              i_d       = n_q;
              wr_addr_d = pos_q[AW-1:0];
              wr_rec_d  = '{hash: hash_q, name: name_q, value: val_in_q};
              state_d   = S_SH_CHK;
            end
          end
          REQ_SEARCH: begin
            if (match_q) begin
              res_val_d = match_val_q;
            end else begin
              res_status_d = ST_MISS;
            end
          end
          REQ_UPDATE: begin
            if (match_q) begin
              res_val_d = match_val_q;
              wr_addr_d = idx_q[AW-1:0];
              wr_rec_d  = '{hash: hash_q, name: name_q, value: val_in_q};
              state_d   = S_WR;
            end else begin
              res_status_d = ST_MISS;
            end
          end
          REQ_DELETE: begin
            if (match_q) begin
              i_d     = idx_q;
              state_d = S_SH_CHK;
            end else begin
              res_status_d = ST_MISS;
            end
          end
          default: begin
            res_status_d = ST_MISS;
          end
        endcase
      end
      S_SH_CHK: begin
        if (req_q == REQ_INSERT) begin
          state_d = (i_q > pos_q) ? S_SH_RD : S_WR;
        end else if ((i_q + ONE) < n_q) begin
          state_d = S_SH_RD;
        end else begin
          n_d     = n_q - ONE;
          state_d = S_FIN;
        end
      end
      S_SH_RD: begin
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        // word moved one slot, step towards the gap
        i_d     = (req_q == REQ_INSERT) ? (i_q - ONE) : (i_q + ONE);
        state_d = S_SH_CHK;
      end
      S_WR: begin
        if (req_q == REQ_INSERT) begin
          n_d = n_q + ONE;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = match_q;
          out_val_d    = res_val_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= REQ_INSERT;
      hash_q       <= '0;
      name_q       <= '0;
      val_in_q     <= '0;
      n_q          <= '0;
      i_q          <= '0;
      pos_q        <= '0;
      pos_set_q    <= 1'b0;
      idx_q        <= '0;
      match_q      <= 1'b0;
      match_val_q  <= '0;
      wr_addr_q    <= '0;
      wr_rec_q     <= '0;
      res_status_q <= ST_DONE;
      res_val_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_DONE;
      out_found_q  <= 1'b0;
      out_val_q    <= '0;
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      hash_q       <= hash_d;
      name_q       <= name_d;
      val_in_q     <= val_in_d;
      n_q          <= n_d;
      i_q          <= i_d;
      pos_q        <= pos_d;
      pos_set_q    <= pos_set_d;
      idx_q        <= idx_d;
      match_q      <= match_d;
      match_val_q  <= match_val_d;
      wr_addr_q    <= wr_addr_d;
      wr_rec_q     <= wr_rec_d;
      res_status_q <= res_status_d;
      res_val_q    <= res_val_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_val_q    <= out_val_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;
  assign value_out_o = out_val_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CAP_N)
    else $error("record count above capacity");

  a_full_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && (res_status_q == ST_FULL)) |-> ((n_q == CAP_N) && !match_q))
    else $error("full reported with free slots or a match");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR && req_q == REQ_INSERT) |=> (n_q == $past(n_q) + ONE))
    else $error("insert did not grow the table");

  a_miss_no_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (value_out_o == '0))
    else $error("value returned on a failed request");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// self-checking testbench for sorted_keyed_record_table_top
// depends on skrt_pkg and the design sources; keeps its own shadow table for prediction
`timescale 1ns / 100ps

module testbench;
  import skrt_pkg::*;

  localparam int unsigned CAP    = CAPACITY_DEF;
  localparam int unsigned NBYTES = NAME_BYTES_DEF;
  localparam int unsigned POOL_N = 24;
  localparam int unsigned RAND_ITEMS = 850;

  typedef struct {
    req_e        req;
    logic [31:0] hash;
    logic [63:0] name;
    logic [31:0] value;
    bit          pause;
  } req_word_t;

  typedef struct {
    status_e     status;
    logic        found;
    logic [31:0] value;
  } reply_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type = '0;
  logic [31:0] key_hash = '0;
  logic [63:0] key_name = '0;
  logic [31:0] value_in = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [1:0]  status_o;
  logic        found_o;
  logic [31:0] value_out_o;

  sorted_keyed_record_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type),
    .key_hash_i  (key_hash),
    .key_name_i  (key_name),
    .value_in_i  (value_in),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .status_o    (status_o),
    .found_o     (found_o),
    .value_out_o (value_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  req_word_t   pending_q[$];
  reply_word_t reply_q[$];
  req_word_t   next_word;
  int unsigned words_issued = 0;
  int unsigned words_taken  = 0;
  int unsigned err_count    = 0;

  // shadow copy of the record table
  logic [31:0] rec_hash [CAP];
  logic [63:0] rec_name [CAP];
  logic [31:0] rec_value[CAP];
  int unsigned rec_count = 0;

  // key pool for the random part
  logic [31:0] pool_hash[POOL_N];
  logic [63:0] pool_name[POOL_N];

  // no random input gaps or output stalls through this stretch
  wire calm = (words_taken >= 300) && (words_taken < 450);

  function automatic logic [63:0] canon_name(logic [63:0] raw);
    logic [63:0] r;
    bit ended;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= NBYTES || raw[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*i +: 8] = raw[8*i +: 8];
    end
    return r;
  endfunction

  // same name, random bytes after the terminating zero
  function automatic logic [63:0] vary_name(logic [63:0] raw);
    logic [63:0] c;
    logic [63:0] r;
    bit ended;
    c = canon_name(raw);
    r = c;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (ended && $urandom_range(1) == 1) r[8*i +: 8] = 8'($urandom);
      if (c[8*i +: 8] == 8'h00) ended = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [63:0] make_name();
    logic [63:0] r;
    int unsigned len;
    r = '0;
    len = $urandom_range(0, 8);
    for (int i = 0; i < 8; i++)
      if (i < len) r[8*i +: 8] = 8'($urandom_range(1, 255));
    return r;
  endfunction

  function automatic reply_word_t apply_request(req_e req, logic [31:0] h, logic [63:0] raw,
                                               logic [31:0] v);
    reply_word_t r;
    logic [63:0] nm;
    int idx;
    int pos;
    nm = canon_name(raw);
    idx = -1;
    for (int i = 0; i < rec_count; i++)
      if (idx < 0 && rec_hash[i] == h && rec_name[i] == nm) idx = i;
    r.status = ST_DONE;
    r.found  = (idx >= 0);
    r.value  = '0;
    case (req)
      REQ_INSERT: begin
        if (idx >= 0) begin
          r.status = ST_MISS;
        end else if (rec_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          // new record goes in front of any with the same hash
          pos = 0;
          while (pos < rec_count && rec_hash[pos] < h) pos++;
          for (int i = rec_count; i > pos; i--) begin
            rec_hash[i]  = rec_hash[i-1];
            rec_name[i]  = rec_name[i-1];
            rec_value[i] = rec_value[i-1];
          end
          rec_hash[pos]  = h;
          rec_name[pos]  = nm;
          rec_value[pos] = v;
          rec_count++;
        end
      end
      REQ_SEARCH: begin
        if (idx < 0) r.status = ST_MISS;
        else r.value = rec_value[idx];
      end
      REQ_UPDATE: begin
        if (idx < 0) begin
          r.status = ST_MISS;
        end else begin
          r.value = rec_value[idx];
          rec_value[idx] = v;
        end
      end
      default: begin
        if (idx < 0) begin
          r.status = ST_MISS;
        end else begin
          for (int i = idx; i + 1 < rec_count; i++) begin
            rec_hash[i]  = rec_hash[i+1];
            rec_name[i]  = rec_name[i+1];
            rec_value[i] = rec_value[i+1];
          end
          rec_count--;
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_word(req_e req, logic [31:0] h, logic [63:0] nm, logic [31:0] v, bit p);
    req_word_t w;
    w.req   = req;
    w.hash  = h;
    w.name  = nm;
    w.value = v;
    w.pause = p;
    pending_q.push_back(w);
  endtask

  task automatic refresh_pool();
    logic [31:0] hset[6];
    for (int k = 0; k < 6; k++) hset[k] = $urandom;
    if ($urandom_range(1) == 1) hset[0] = 32'h0000_0000;
    if ($urandom_range(1) == 1) hset[5] = 32'hFFFF_FFFF;
    for (int i = 0; i < POOL_N; i++) begin
      pool_hash[i] = hset[$urandom_range(0, 5)];
      pool_name[i] = make_name();
    end
  endtask

  // driver: new word only when the previous one has been taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && words_issued != words_taken)) begin
      if (pending_q.size() > 0 && !(pending_q[0].pause && reply_q.size() > 0) &&
          !(!calm && $urandom_range(99) < 22)) begin
        next_word = pending_q.pop_front();
        req_type <= next_word.req;
        key_hash <= next_word.hash;
        key_name <= next_word.name;
        value_in <= next_word.value;
        in_valid <= 1'b1;
        words_issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 22);
  end

  // monitor: check result words first, then record the accepted request word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("result word with no request outstanding");
          err_count++;
        end else begin
          if (status_o != reply_q[0].status) begin
            $error("status: expected %0d, got %0d", reply_q[0].status, status_o);
            err_count++;
          end
          if (found_o != reply_q[0].found) begin
            $error("found: expected %0d, got %0d", reply_q[0].found, found_o);
            err_count++;
          end
          if (value_out_o != reply_q[0].value) begin
            $error("value_out: expected %h, got %h", reply_q[0].value, value_out_o);
            err_count++;
          end
          void'(reply_q.pop_front());
        end
      end
      if (in_valid && !in_stall_o) begin
        reply_q.push_back(apply_request(req_e'(req_type), key_hash, key_name, value_in));
        words_taken <= words_taken + 1;
      end
    end
  end

  initial begin
    int unsigned total;
    int unsigned phase;
    int unsigned kind;
    int unsigned n;
    int unsigned pick;
    int unsigned roll;
    bit pause;
    req_e op;
    logic [31:0] h;
    logic [63:0] nm;

    // directed: misses on an empty table, extremes, name handling, duplicate, delete
    add_word(REQ_SEARCH, 32'h0, 64'h0, 32'h0, 1'b0);
    add_word(REQ_UPDATE, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b0);
    add_word(REQ_DELETE, 32'h0, 64'h0, 32'h0, 1'b0);
    add_word(REQ_INSERT, 32'h0, 64'h0, 32'h0, 1'b0);
    add_word(REQ_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_word(REQ_INSERT, 32'h8000_0000, 64'h6261, 32'h1234_5678, 1'b0);
    add_word(REQ_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5555_5555, 1'b0);
    add_word(REQ_INSERT, 32'h8000_0000, 64'h0063_6261, 32'hAAAA_AAAA, 1'b0);
    // junk after the zero byte must not matter
    add_word(REQ_SEARCH, 32'h8000_0000, 64'hA5A5_A5A5_0063_6261, 32'h0, 1'b0);
    add_word(REQ_UPDATE, 32'h8000_0000, 64'h5A00_0000_0063_6261, 32'hC3C3_3C3C, 1'b0);
    add_word(REQ_SEARCH, 32'h8000_0000, 64'h0063_6261, 32'h0, 1'b0);
    // leading zero byte makes an empty name
    add_word(REQ_SEARCH, 32'h0, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 1'b0);
    add_word(REQ_SEARCH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
    add_word(REQ_DELETE, 32'h8000_0000, 64'h6261, 32'hFFFF_FFFF, 1'b0);
    add_word(REQ_SEARCH, 32'h8000_0000, 64'h6261, 32'h0, 1'b0);
    add_word(REQ_DELETE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
    add_word(REQ_SEARCH, 32'h8000_0000, 64'h0063_6261, 32'h0, 1'b0);
    add_word(REQ_UPDATE, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b0);

    // random: phases over a small key pool so hits, shared hashes and a full table occur
    total = 0;
    phase = 0;
    while (total < RAND_ITEMS) begin
      if (phase % 4 == 0) refresh_pool();
      kind  = (phase % 4 == 0) ? 0 : $urandom_range(0, 2);
      pause = (phase == 1) || ($urandom_range(0, 5) == 0);
      n = $urandom_range(20, 40);
      for (int j = 0; j < n; j++) begin
        roll = $urandom_range(99);
        case (kind)
          0:       op = (roll < 80) ? REQ_INSERT : REQ_SEARCH;
          1:       op = req_e'($urandom_range(0, 3));
          default: op = (roll < 60) ? REQ_DELETE : (roll < 80) ? REQ_SEARCH : REQ_UPDATE;
        endcase
        if ($urandom_range(9) == 0) begin
          h  = $urandom;
          nm = {$urandom, $urandom};
        end else begin
          pick = $urandom_range(0, POOL_N - 1);
          h  = pool_hash[pick];
          nm = vary_name(pool_name[pick]);
        end
        add_word(op, h, nm, $urandom, pause && j == 0);
        total++;
      end
      phase++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_q.size() == 0 && words_issued == words_taken && reply_q.size() == 0))
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (err_count == 0) begin
      $display("** sorted_keyed_record_table_top: PASSED **");
    end else begin
      $display("** sorted_keyed_record_table_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** sorted_keyed_record_table_top: FAILED **");
    $finish;
  end

endmodule
